// ===== src/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and codes of the timer slot table.
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_STOP   = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOEXS = 2'd1;
    localparam logic [1:0] ST_PAR   = 2'd2;

    localparam logic [9:0] TICK_RESET  = 10'd10;
    localparam logic [3:0] MAX_RESULTS = 4'd8;

    // one slot's stored word
    typedef struct packed {
        logic [23:0] remaining;
        logic [31:0] stamp;
        logic [31:0] tag;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [31:0] stamp;
        logic [31:0] tag;
        logic        last;
    } result_t;

endpackage

// ===== src/tst_slot_mem.sv =====
// ----------------------------------------------------------------------------
// tst_slot_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tst_slot_mem #(
    parameter int NUM_SLOTS = 8
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] wr_addr,
    input  tst_pkg::entry_t                         wr_data,
    input  logic                                    rd_en,
    input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] rd_addr,
    output tst_pkg::entry_t                         rd_data
);

    tst_pkg::entry_t mem [NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/tst_ctrl.sv =====
// ----------------------------------------------------------------------------
// tst_ctrl
// Command sequencer: busy flags, stamp counter, slot scan and result register.
// ----------------------------------------------------------------------------
module tst_ctrl #(
    parameter int NUM_SLOTS = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [9:0]       cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_command,
    input  logic [23:0]      in_timeout_ms,
    input  logic [31:0]      in_user_tag,
    input  logic [7:0]       in_slot_index,
    input  logic [31:0]      in_handle_stamp,
    output logic             out_valid,
    input  logic             out_ready,
    output tst_pkg::result_t out_result
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK_RD,
        S_TICK_EV,
        S_TICK_FIN,
        S_STOP_EV
    } state_t;

    state_t               state_reg, state_next;
    logic [9:0]           tick_reg, tick_next;
    logic [NUM_SLOTS-1:0] in_use_reg, in_use_next;
    logic [31:0]          stamp_ctr_reg, stamp_ctr_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [3:0]           n_reg, n_next;
    logic                 pend_valid_reg, pend_valid_next;
    tst_pkg::result_t     pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    tst_pkg::result_t     out_reg, out_next;

    logic [1:0]           cmd_reg, cmd_next;
    logic [23:0]          timeout_reg, timeout_next;
    logic [31:0]          tag_reg, tag_next;
    logic [7:0]           sidx_reg, sidx_next;
    logic [31:0]          hstamp_reg, hstamp_next;

    logic                 mem_wr_en, mem_rd_en;
    logic [IDX_W-1:0]     mem_wr_addr, mem_rd_addr;
    tst_pkg::entry_t      mem_wr_data, mem_rd_data;

    logic                 out_free, out_load;
    tst_pkg::result_t     res;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic [7:0]           free_wide, idx_wide;
    logic                 sidx_in_range;
    logic [IDX_W-1:0]     sidx_trunc;
    logic                 expire, scan_end;
    logic [23:0]          tick_wide;

    tst_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign out_free   = !out_valid_reg || out_ready;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign free_wide     = 8'(free_idx);
    assign idx_wide      = 8'(idx_reg);
    assign sidx_in_range = ({1'b0, sidx_reg} < 9'(NUM_SLOTS));
    assign sidx_trunc    = sidx_reg[IDX_W-1:0];
    assign tick_wide     = {14'd0, tick_reg};
    assign expire        = (mem_rd_data.remaining <= tick_wide);
    assign scan_end      = (idx_reg == IDX_W'(NUM_SLOTS - 1));

    always_comb
    begin
        state_next      = state_reg;
        tick_next       = cfg_we ? cfg_wdata : tick_reg;
        in_use_next     = in_use_reg;
        stamp_ctr_next  = stamp_ctr_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cmd_next        = cmd_reg;
        timeout_next    = timeout_reg;
        tag_next        = tag_reg;
        sidx_next       = sidx_reg;
        hstamp_next     = hstamp_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = idx_reg;
        mem_wr_data     = mem_rd_data;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = idx_reg;
        out_load        = 1'b0;
        res             = '0;
        res.last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = in_command;
                    timeout_next = in_timeout_ms;
                    tag_next     = in_user_tag;
                    sidx_next    = in_slot_index;
                    hstamp_next  = in_handle_stamp;
                    state_next   = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (cmd_reg)
                    tst_pkg::CMD_TICK:
                    begin
                        idx_next        = '0;
                        n_next          = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_TICK_RD;
                    end
                    tst_pkg::CMD_START:
                    begin
                        res.kind = tst_pkg::KIND_START;
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (timeout_reg <= tick_wide)
                            begin
                                res.status = tst_pkg::ST_PAR;
                            end
                            else if (free_found)
                            begin
                                res.status            = tst_pkg::ST_OK;
                                res.slot              = free_wide[2:0];
                                res.stamp             = stamp_ctr_reg;
                                mem_wr_en             = 1'b1;
                                mem_wr_addr           = free_idx;
                                mem_wr_data.remaining = timeout_reg;
                                mem_wr_data.stamp     = stamp_ctr_reg;
                                mem_wr_data.tag       = tag_reg;
                                in_use_next[free_idx] = 1'b1;
                                stamp_ctr_next        = stamp_ctr_reg + 32'd1;
                            end
                            else
                            begin
                                res.status = tst_pkg::ST_NOEXS;
                            end
                        end
                    end
                    tst_pkg::CMD_STOP:
                    begin
                        res.kind = tst_pkg::KIND_STOP;
                        if (!sidx_in_range)
                        begin
                            res.status = tst_pkg::ST_PAR;
                            if (out_free)
                            begin
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else if (!in_use_reg[sidx_trunc])
                        begin
                            res.status = tst_pkg::ST_NOEXS;
                            res.slot   = sidx_reg[2:0];
                            if (out_free)
                            begin
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = sidx_trunc;
                            state_next  = S_STOP_EV;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_STOP_EV:
            begin
                res.kind = tst_pkg::KIND_STOP;
                res.slot = sidx_reg[2:0];
                if (mem_rd_data.stamp == hstamp_reg)
                begin
                    res.status = tst_pkg::ST_OK;
                    res.stamp  = hstamp_reg;
                end
                else
                begin
                    res.status = tst_pkg::ST_NOEXS;
                end
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (mem_rd_data.stamp == hstamp_reg)
                    begin
                        in_use_next[sidx_trunc] = 1'b0;
                    end
                end
            end

            S_TICK_RD:
            begin
                if (in_use_reg[idx_reg])
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_TICK_EV;
                end
                else if (scan_end)
                begin
                    state_next = S_TICK_FIN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_TICK_EV:
            begin
                res = pend_reg;
                res.last = 1'b0;
                // an expiry waits here while the previous one cannot leave yet
                if (!(expire && n_reg != tst_pkg::MAX_RESULTS
                      && pend_valid_reg && !out_free))
                begin
                    mem_wr_en = 1'b1;
                    if (!expire)
                    begin
                        mem_wr_data.remaining = mem_rd_data.remaining - tick_wide;
                    end
                    else if (n_reg == tst_pkg::MAX_RESULTS)
                    begin
                        // over the per-tick limit: keep busy, fire next tick
                        mem_wr_data.remaining = 24'd1;
                    end
                    else
                    begin
                        mem_wr_data.remaining = '0;
                        out_load              = pend_valid_reg;
                        pend_valid_next       = 1'b1;
                        pend_next.kind        = tst_pkg::KIND_EXPIRY;
                        pend_next.status      = tst_pkg::ST_OK;
                        pend_next.slot        = idx_wide[2:0];
                        pend_next.stamp       = mem_rd_data.stamp;
                        pend_next.tag         = mem_rd_data.tag;
                        pend_next.last        = 1'b0;
                        in_use_next[idx_reg]  = 1'b0;
                        n_next                = n_reg + 4'd1;
                    end
                    if (scan_end)
                    begin
                        state_next = S_TICK_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_TICK_RD;
                    end
                end
            end

            S_TICK_FIN:
            begin
                res = pend_reg;
                res.last = 1'b1;
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= tst_pkg::TICK_RESET;
            in_use_reg     <= '0;
            stamp_ctr_reg  <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            in_use_reg     <= in_use_next;
            stamp_ctr_reg  <= stamp_ctr_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        cmd_reg     <= cmd_next;
        timeout_reg <= timeout_next;
        tag_reg     <= tag_next;
        sidx_reg    <= sidx_next;
        hstamp_reg  <= hstamp_next;
    end

endmodule

// ===== src/timer_slot_table.sv =====
// ----------------------------------------------------------------------------
// timer_slot_table
// Table of one-shot timer slots driven by tick, start and stop commands.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream (kind in s_tuser), results leave on the
// m_ stream (kind in m_tuser, final result of a command on m_tlast).
// cfg_we loads tick_interval; write it only while the block is idle.
// Start and stop give one reply each. A tick gives one expiry per slot that
// runs out (at most 8), in slot order, and nothing if none expires.
// Timing: a command is taken when the sequencer is idle. Start is a transfer,
// then a decode with the reply loaded; stop adds one slot memory read before
// the reply when the slot is busy. A tick scans the slots one at a time: an
// idle slot is stepped over, a busy slot is read, then written back; the scan
// follows the transfer and decode and ends with the final result.
// A result sits in an output register; a new command can be taken while it
// waits. When m_tready is low the sequencer holds at the next result.
// Reset clears the busy flags, the stamp counter and the output valid flag; slot memory
// contents are ignored until a start writes them.
// ----------------------------------------------------------------------------
module timer_slot_table #(
    parameter int NUM_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,     // tick_interval
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,       // timeout_ms, user_tag, slot_index, handle_stamp
    input  logic [1:0]  s_tuser,       // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,       // status, slot, stamp, tag_out, zero pad
    output logic [1:0]  m_tuser,       // event_kind
    output logic        m_tlast
);

    tst_pkg::result_t res;

    tst_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_command      (s_tuser),
        .in_timeout_ms   (s_tdata[23:0]),
        .in_user_tag     (s_tdata[55:24]),
        .in_slot_index   (s_tdata[63:56]),
        .in_handle_stamp (s_tdata[95:64]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_result      (res)
    );

    assign m_tdata = {3'd0, res.tag, res.stamp, res.slot, res.status};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

// ===== src/tst_checker.sv =====
// ----------------------------------------------------------------------------
// tst_checker
// Port-level checks of the timer slot table, bound to the top level.
// ----------------------------------------------------------------------------
module tst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // held result must not change under backpressure
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // start and stop replies are single results
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != tst_pkg::KIND_EXPIRY |-> m_tlast)
        else $error("reply not marked last");

    // expiries always report ok
    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == tst_pkg::KIND_EXPIRY |-> m_tdata[1:0] == tst_pkg::ST_OK)
        else $error("expiry with error status");

    // failed start carries no slot or stamp
    a_start_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == tst_pkg::KIND_START && m_tdata[1:0] != tst_pkg::ST_OK
            |-> m_tdata[36:2] == 35'd0)
        else $error("failed start with slot or stamp");

    // a command transfer keeps the sequencer busy for at least the next cycle
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while busy");

endmodule

bind timer_slot_table tst_checker u_tst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timer slot table: commands go in on the s_
// stream, every reply and expiry on the m_ stream is checked field by field
// against an in-bench model of the slot table, with random stalls on both
// sides and several tick intervals.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SLOTS         = 8;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         STALL_LIMIT   = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [9:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // model of the slot table
    logic [9:0]  tick_ms;
    logic        slot_busy [SLOTS];
    logic [23:0] slot_left [SLOTS];
    logic [31:0] slot_stamp_m [SLOTS];
    logic [31:0] slot_tag_m [SLOTS];
    logic [31:0] stamp_count;

    tst_pkg::result_t pending_results [$];
    int               fail_count;
    int               quiet_cycles = 0;
    bit               calm;

    timer_slot_table #(
        .NUM_SLOTS(SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic model_reset();
        tick_ms = tst_pkg::TICK_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i]    = 1'b0;
            slot_left[i]    = '0;
            slot_stamp_m[i] = '0;
            slot_tag_m[i]   = '0;
        end
        stamp_count = '0;
    endtask

    function automatic tst_pkg::result_t make_result(logic [1:0] kind, logic [1:0] status,
                                                     logic [2:0] slot, logic [31:0] stamp,
                                                     logic [31:0] tag, logic last);
        tst_pkg::result_t r;
        r.kind   = kind;
        r.status = status;
        r.slot   = slot;
        r.stamp  = stamp;
        r.tag    = tag;
        r.last   = last;
        return r;
    endfunction

    // update the model for one accepted command and queue its results
    task automatic model_command(input logic [1:0] cmd, input logic [23:0] timeout,
                                 input logic [31:0] tag, input logic [7:0] sidx,
                                 input logic [31:0] hstamp);
        tst_pkg::result_t burst [$];
        int               free_slot;
        free_slot = -1;
        case (cmd)
            tst_pkg::CMD_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_busy[i])
                    begin
                        if (slot_left[i] <= tick_ms)
                        begin
                            if (burst.size() >= tst_pkg::MAX_RESULTS)
                                slot_left[i] = 24'd1;
                            else
                            begin
                                burst.push_back(make_result(tst_pkg::KIND_EXPIRY,
                                                            tst_pkg::ST_OK, 3'(i),
                                                            slot_stamp_m[i], slot_tag_m[i],
                                                            1'b0));
                                slot_busy[i] = 1'b0;
                                slot_left[i] = '0;
                            end
                        end
                        else
                            slot_left[i] = slot_left[i] - tick_ms;
                    end
                end
                if (burst.size() > 0)
                    burst[burst.size() - 1].last = 1'b1;
                foreach (burst[k])
                    pending_results.push_back(burst[k]);
            end
            tst_pkg::CMD_START:
            begin
                if (timeout <= tick_ms)
                    pending_results.push_back(make_result(tst_pkg::KIND_START, tst_pkg::ST_PAR,
                                                          '0, '0, '0, 1'b1));
                else
                begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slot_busy[i])
                            free_slot = i;
                    if (free_slot < 0)
                        pending_results.push_back(make_result(tst_pkg::KIND_START,
                                                              tst_pkg::ST_NOEXS, '0, '0, '0,
                                                              1'b1));
                    else
                    begin
                        slot_busy[free_slot]    = 1'b1;
                        slot_left[free_slot]    = timeout;
                        slot_stamp_m[free_slot] = stamp_count;
                        slot_tag_m[free_slot]   = tag;
                        stamp_count             = stamp_count + 32'd1;
                        pending_results.push_back(make_result(tst_pkg::KIND_START,
                                                              tst_pkg::ST_OK, 3'(free_slot),
                                                              slot_stamp_m[free_slot], '0,
                                                              1'b1));
                    end
                end
            end
            tst_pkg::CMD_STOP:
            begin
                if (sidx >= SLOTS)
                    pending_results.push_back(make_result(tst_pkg::KIND_STOP, tst_pkg::ST_PAR,
                                                          '0, '0, '0, 1'b1));
                else if (!slot_busy[sidx] || slot_stamp_m[sidx] != hstamp)
                    pending_results.push_back(make_result(tst_pkg::KIND_STOP,
                                                          tst_pkg::ST_NOEXS, sidx[2:0], '0,
                                                          '0, 1'b1));
                else
                begin
                    slot_busy[sidx] = 1'b0;
                    slot_left[sidx] = '0;
                    pending_results.push_back(make_result(tst_pkg::KIND_STOP, tst_pkg::ST_OK,
                                                          sidx[2:0], hstamp, '0, 1'b1));
                end
            end
            default:
            begin
                // undefined command is dropped by the block
            end
        endcase
    endtask

    // one command transfer on the s_ side; the model is updated at the accepting edge
    task automatic issue_command(input logic [1:0] cmd, input logic [23:0] timeout,
                                 input logic [31:0] tag, input logic [7:0] sidx,
                                 input logic [31:0] hstamp);
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {hstamp, sidx, tag, timeout};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model_command(cmd, timeout, tag, sidx, hstamp);
    endtask

    // drop valid, wait for every queued result, then let a silent tick finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_tick_interval(input logic [9:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tick_ms   = value;
    endtask

    task automatic random_command(output bit counted);
        logic [1:0]  cmd;
        logic [23:0] tmo;
        logic [31:0] tag;
        logic [31:0] hs;
        logic [7:0]  sidx;
        int          busy_list [$];
        int          pick;
        pick    = $urandom_range(0, 99);
        tag     = $urandom;
        hs      = $urandom;
        sidx    = 8'($urandom_range(0, 255));
        tmo     = 24'($urandom_range(0, 24'hFFFFFF));
        counted = 1'b1;
        if (pick < 40)
        begin
            cmd = tst_pkg::CMD_START;
            case ($urandom_range(0, 9))
                0:       tmo = 24'($urandom_range(0, tick_ms));
                1:       ;
                default: tmo = tick_ms + 24'($urandom_range(1, 3 * tick_ms + 3));
            endcase
        end
        else if (pick < 70)
            cmd = tst_pkg::CMD_TICK;
        else if (pick < 95)
        begin
            cmd = tst_pkg::CMD_STOP;
            for (int i = 0; i < SLOTS; i++)
                if (slot_busy[i])
                    busy_list.push_back(i);
            if (busy_list.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                sidx = 8'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
                hs   = slot_stamp_m[sidx];
                if ($urandom_range(0, 7) == 0)
                    hs[$urandom_range(0, 31)] ^= 1'b1;
            end
            else if ($urandom_range(0, 1) == 0)
                sidx = 8'($urandom_range(0, 15));
        end
        else
        begin
            cmd     = CMD_UNUSED;
            counted = 1'b0;
        end
        issue_command(cmd, tmo, tag, sidx, hs);
    endtask

    task automatic run_random(input int count, input int pause_at);
        int done;
        bit counted;
        done = 0;
        while (done < count)
        begin
            random_command(counted);
            if (counted)
                done++;
            if (counted && done == pause_at)
                wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // tests

    task automatic test_start_and_stop();
        issue_command(tst_pkg::CMD_START, 24'd10, 32'h1234_5678, '0, '0);  // equal to interval
        issue_command(tst_pkg::CMD_START, 24'd0, '0, '0, '0);
        issue_command(tst_pkg::CMD_START, 24'd11, 32'hFFFF_FFFF, '0, '0);
        issue_command(tst_pkg::CMD_STOP, '0, '0, 8'd0, 32'd1);             // wrong stamp
        issue_command(tst_pkg::CMD_STOP, '0, '0, 8'd8, '0);                // out of range
        issue_command(tst_pkg::CMD_STOP, 24'hFFFFFF, 32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);
        issue_command(tst_pkg::CMD_STOP, '0, '0, 8'd3, '0);                // idle slot
        issue_command(tst_pkg::CMD_STOP, '0, '0, 8'd0, 32'd0);
        issue_command(CMD_UNUSED, 24'hFFFFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        issue_command(tst_pkg::CMD_TICK, '0, '0, '0, '0);                  // nothing running
        wait_idle();
    endtask

    task automatic test_full_table();
        write_tick_interval(10'd1000);
        for (int i = 0; i < SLOTS - 1; i++)
            issue_command(tst_pkg::CMD_START, 24'(1001 + 100 * i), $urandom, '0, '0);
        issue_command(tst_pkg::CMD_START, 24'd2000, 32'h0, '0, '0);
        issue_command(tst_pkg::CMD_START, 24'd5000, $urandom, '0, '0);     // no free slot
        issue_command(tst_pkg::CMD_TICK, '0, '0, '0, '0);
        issue_command(tst_pkg::CMD_TICK, '0, '0, '0, '0);                  // all slots expire
        issue_command(tst_pkg::CMD_START, 24'hFFFFFF, 32'h0, '0, '0);
        issue_command(tst_pkg::CMD_STOP, '0, '0, 8'd0, slot_stamp_m[0]);
        wait_idle();
    endtask

    task automatic test_min_interval();
        write_tick_interval(10'd1);
        issue_command(tst_pkg::CMD_START, 24'd1, $urandom, '0, '0);
        issue_command(tst_pkg::CMD_START, 24'd2, $urandom, '0, '0);
        issue_command(tst_pkg::CMD_TICK, '0, '0, '0, '0);
        issue_command(tst_pkg::CMD_TICK, '0, '0, '0, '0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       write_tick_interval(10'd1);
                1:       write_tick_interval(10'd1000);
                2:       write_tick_interval(10'($urandom_range(1, 50)));
                default: write_tick_interval(10'($urandom_range(1, 1000)));
            endcase
            run_random(30, (phase == 2) ? 15 : -1);
        end
    endtask

    task automatic test_full_rate();
        write_tick_interval(10'($urandom_range(1, 100)));
        calm = 1'b1;
        run_random(30, -1);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = tst_pkg::CMD_TICK;
        fail_count = 0;
        calm       = 1'b0;
        model_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_start_and_stop();
        test_full_table();
        test_min_interval();
        test_random_traffic();
        test_full_rate();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver back-pressure in bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!calm && stall_left == 0 && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        tst_pkg::result_t got;
        tst_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind   = m_tuser;
            got.status = m_tdata[1:0];
            got.slot   = m_tdata[4:2];
            got.stamp  = m_tdata[36:5];
            got.tag    = m_tdata[68:37];
            got.last   = m_tlast;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual kind %0d slot %0d",
                         $time, got.kind, got.slot);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("event_kind", 32'(want.kind), 32'(got.kind));
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("slot", 32'(want.slot), 32'(got.slot));
                check_field("stamp", want.stamp, got.stamp);
                check_field("tag_out", want.tag, got.tag);
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    // watchdog: cycles with no transfer on either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
